// ===== hw/rtl/max_heap_priority_queue_top_macros.svh =====
// Assertion macros for the heap queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define MHPQ_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
	else $error("mhpq assertion failed");
// checked at every edge, reset included
`define MHPQ_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) (prop)) \
	else $error("mhpq assertion failed");
`else
`define MHPQ_ASSERT(lbl, ck, rn, prop)
`define MHPQ_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

// ===== hw/rtl/mhpq_pkg.sv =====
package mhpq_pkg;
	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int EXT_W    = ADDR_W + 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_DEL_RD_LAST,
		S_DEL_LOAD,
		S_DEL_CHK,
		S_DEL_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic start;
		logic ins_chk;
		logic ins_cmp;
		logic rd_last;
		logic load_last;
		logic del_chk;
		logic del_cmp;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic single;
		logic at_root;
		logic no_child;
		logic ins_move;
		logic del_move;
	} stat_t;
endpackage

// ===== hw/rtl/mhpq_dp.sv =====
`include "max_heap_priority_queue_top_macros.svh"
module mhpq_dp
	import mhpq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic                    operation,
	input  logic signed [KEY_W-1:0] key_value,
	output stat_t                   stat,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] removed_key,
	output logic                    top_valid,
	output logic signed [KEY_W-1:0] top_key,
	output logic [CNT_W-1:0]        entry_total
);
	logic signed [KEY_W-1:0] heap_mem [CAPACITY];

	logic [CNT_W-1:0]        cnt_q;
	logic [ADDR_W-1:0]       pos_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] top_q;
	logic signed [KEY_W-1:0] removed_q;
	status_t                 status_q;
	logic signed [KEY_W-1:0] rd_a_q;
	logic signed [KEY_W-1:0] rd_b_q;
	logic [1:0]              out_status_q;
	logic signed [KEY_W-1:0] out_removed_q;
	logic                    out_top_valid_q;
	logic signed [KEY_W-1:0] out_top_q;
	logic [CNT_W-1:0]        out_total_q;

	logic [EXT_W-1:0]        lc_ext;
	logic [EXT_W-1:0]        rc_ext;
	logic [EXT_W-1:0]        cnt_ext;
	logic [ADDR_W-1:0]       par_idx;
	logic                    rc_ok;
	logic                    pick_r;
	logic signed [KEY_W-1:0] big_key;
	logic [ADDR_W-1:0]       big_idx;
	logic [ADDR_W-1:0]       rd_a_addr;
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic signed [KEY_W-1:0] wr_data;
	logic                    take_ins;
	logic                    take_del;

	assign lc_ext  = EXT_W'({pos_q, 1'b1});
	assign rc_ext  = lc_ext + EXT_W'(1);
	assign cnt_ext = EXT_W'(cnt_q);
	assign par_idx = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
	assign rc_ok   = rc_ext < cnt_ext;
	assign pick_r  = rc_ok && (rd_a_q < rd_b_q);
	assign big_key = pick_r ? rd_b_q : rd_a_q;
	assign big_idx = pick_r ? rc_ext[ADDR_W-1:0] : lc_ext[ADDR_W-1:0];

	assign stat.full     = cnt_q == CNT_W'(CAPACITY);
	assign stat.empty    = cnt_q == '0;
	assign stat.single   = cnt_q == CNT_W'(1);
	assign stat.at_root  = pos_q == '0;
	assign stat.no_child = lc_ext >= cnt_ext;
	assign stat.ins_move = rd_a_q < key_q;
	assign stat.del_move = key_q < big_key;

	assign take_ins = cmd.start && (op_t'(operation) == OP_INSERT) && !stat.full;
	assign take_del = cmd.start && (op_t'(operation) == OP_DELETE) && !stat.empty;

	always_comb begin
		priority if (cmd.ins_chk) begin
			rd_a_addr = par_idx;
		end else if (cmd.rd_last) begin
			rd_a_addr = cnt_q[ADDR_W-1:0];
		end else begin
			rd_a_addr = lc_ext[ADDR_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = key_q;
		if (cmd.ins_chk && stat.at_root) begin
			wr_en = 1'b1;
		end
		if (cmd.ins_cmp) begin
			wr_en = 1'b1;
			if (stat.ins_move) begin
				wr_data = rd_a_q;
			end
		end
		if (cmd.del_chk && stat.no_child) begin
			wr_en = 1'b1;
		end
		if (cmd.del_cmp) begin
			wr_en = 1'b1;
			if (stat.del_move) begin
				wr_data = big_key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= heap_mem[rd_a_addr];
		rd_b_q <= heap_mem[rc_ext[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take_ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (take_del) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= key_value;
			if (op_t'(operation) == OP_INSERT) begin
				pos_q     <= cnt_q[ADDR_W-1:0];
				removed_q <= '0;
				status_q  <= stat.full ? ST_FULL : ST_OK;
			end else begin
				pos_q     <= '0;
				removed_q <= stat.empty ? '0 : top_q;
				status_q  <= stat.empty ? ST_EMPTY : ST_OK;
			end
		end
		if (cmd.load_last) begin
			key_q <= rd_a_q;
		end
		if (cmd.ins_cmp && stat.ins_move) begin
			pos_q <= par_idx;
		end
		if (cmd.del_cmp && stat.del_move) begin
			pos_q <= big_idx;
		end
		if (wr_en && wr_addr == '0) begin
			top_q <= wr_data;
		end
		if (cmd.respond) begin
			out_status_q    <= status_q;
			out_removed_q   <= removed_q;
			out_top_valid_q <= !stat.empty;
			out_top_q       <= stat.empty ? '0 : top_q;
			out_total_q     <= cnt_q;
		end
	end

	assign status      = out_status_q;
	assign removed_key = out_removed_q;
	assign top_valid   = out_top_valid_q;
	assign top_key     = out_top_q;
	assign entry_total = out_total_q;

	`MHPQ_ASSERT_ALWAYS(a_cnt_bound, clk, !arst_n || cnt_q <= CNT_W'(CAPACITY))
	`MHPQ_ASSERT(a_ins_count, clk, arst_n, take_ins |=> cnt_q == $past(cnt_q) + CNT_W'(1))
	`MHPQ_ASSERT(a_root_track, clk, arst_n, (wr_en && wr_addr == '0) |=> top_q == $past(wr_data))
endmodule

// ===== hw/rtl/mhpq_ctrl.sv =====
`include "max_heap_priority_queue_top_macros.svh"
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  operation,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_load;

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op_t'(operation) == OP_INSERT) begin
						state_d = stat.full ? S_RESP : S_INS_CHK;
					end else begin
						state_d = (stat.empty || stat.single) ? S_RESP : S_DEL_RD_LAST;
					end
				end
			end
			S_INS_CHK:     state_d = stat.at_root ? S_RESP : S_INS_CMP;
			S_INS_CMP:     state_d = stat.ins_move ? S_INS_CHK : S_RESP;
			S_DEL_RD_LAST: state_d = S_DEL_LOAD;
			S_DEL_LOAD:    state_d = S_DEL_CHK;
			S_DEL_CHK:     state_d = stat.no_child ? S_RESP : S_DEL_CMP;
			S_DEL_CMP:     state_d = stat.del_move ? S_DEL_CHK : S_RESP;
			S_RESP: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			default:       state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_INS_CHK:     cmd.ins_chk   = 1'b1;
			S_INS_CMP:     cmd.ins_cmp   = 1'b1;
			S_DEL_RD_LAST: cmd.rd_last   = 1'b1;
			S_DEL_LOAD:    cmd.load_last = 1'b1;
			S_DEL_CHK:     cmd.del_chk   = 1'b1;
			S_DEL_CMP:     cmd.del_cmp   = 1'b1;
			S_RESP:        cmd.respond   = can_load;
			default:       cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MHPQ_ASSERT(a_no_overwrite, clk, arst_n, cmd.respond |-> (!out_valid_q || out_ready))
	`MHPQ_ASSERT(a_one_at_a_time, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	`MHPQ_ASSERT(a_resp_shows, clk, arst_n, cmd.respond |=> out_valid_q)
endmodule

// ===== hw/rtl/max_heap_priority_queue_top.sv =====
// Insert: the new key climbs through the check and compare states one level at a time;
// delete: the last entry is read and loaded at the root, then sinks one level at a time;
// full, empty and single-entry cases go straight to the response state.
// One word is in flight at a time, paced by the single-write heap store
// walked one level per compare; the next word is taken while the previous result waits.
// Reset: arst_n clears the entry count and control; heap store contents are not cleared.
module max_heap_priority_queue_top
	import mhpq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    operation,
	input  logic signed [KEY_W-1:0] key_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] removed_key,
	output logic                    top_valid,
	output logic signed [KEY_W-1:0] top_key,
	output logic [CNT_W-1:0]        entry_total
);
	cmd_t  cmd;
	stat_t stat;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mhpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.key_value   (key_value),
		.stat        (stat),
		.status      (status),
		.removed_key (removed_key),
		.top_valid   (top_valid),
		.top_key     (top_key),
		.entry_total (entry_total)
	);
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import mhpq_pkg::*;

typedef struct {
	status_t                 st;
	logic signed [KEY_W-1:0] removed;
	logic                    top_valid;
	logic signed [KEY_W-1:0] top;
	logic [CNT_W-1:0]        total;
} heap_result_t;

class heap_scoreboard;
	logic signed [KEY_W-1:0] slots[CAPACITY];
	int                      fill;
	heap_result_t            awaited[$];
	int                      errors;

	function new();
		fill = 0;
		errors = 0;
	endfunction

	function void note_word(op_t op, logic signed [KEY_W-1:0] key);
		heap_result_t            r;
		int                      pos;
		int                      lc;
		int                      big;
		bit                      sinking;
		logic signed [KEY_W-1:0] t;
		r.st = ST_OK;
		r.removed = '0;
		if (op == OP_INSERT) begin
			if (fill >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				slots[fill] = key;
				pos = fill;
				while (pos != 0 && slots[(pos - 1) / 2] < slots[pos]) begin
					t = slots[pos];
					slots[pos] = slots[(pos - 1) / 2];
					slots[(pos - 1) / 2] = t;
					pos = (pos - 1) / 2;
				end
				fill++;
			end
		end else begin
			if (fill == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.removed = slots[0];
				fill--;
				if (fill > 0) begin
					slots[0] = slots[fill];
					pos = 0;
					sinking = 1'b1;
					while (sinking) begin
						lc = 2 * pos + 1;
						if (lc >= fill) begin
							sinking = 1'b0;
						end else begin
							// left child wins a tie, right only when strictly larger
							big = lc;
							if (lc + 1 < fill && slots[lc] < slots[lc + 1])
								big = lc + 1;
							if (slots[pos] < slots[big]) begin
								t = slots[pos];
								slots[pos] = slots[big];
								slots[big] = t;
								pos = big;
							end else begin
								sinking = 1'b0;
							end
						end
					end
				end
			end
		end
		r.top_valid = (fill > 0);
		r.top = (fill > 0) ? slots[0] : '0;
		r.total = CNT_W'(fill);
		awaited.push_back(r);
	endfunction

	function void check_result(logic [1:0] st, logic signed [KEY_W-1:0] removed,
			logic tv, logic signed [KEY_W-1:0] top, logic [CNT_W-1:0] total);
		heap_result_t e;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected result word, status %0d top %0d total %0d",
					$realtime, st, top, total);
			return;
		end
		e = awaited.pop_front();
		if (st !== e.st || removed !== e.removed || tv !== e.top_valid ||
				top !== e.top || total !== e.total) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: result mismatch", $realtime);
				$display("  expected status %0d removed %0d top_valid %0d top %0d total %0d",
					e.st, e.removed, e.top_valid, e.top, e.total);
				$display("  actual   status %0d removed %0d top_valid %0d top %0d total %0d",
					st, removed, tv, top, total);
			end
		end
	endfunction
endclass

module testbench;
	import mhpq_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_WORDS   = 440;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    operation;
	logic signed [KEY_W-1:0] key_value;
	logic                    out_valid;
	logic                    out_ready;
	logic [1:0]              status;
	logic signed [KEY_W-1:0] removed_key;
	logic                    top_valid;
	logic signed [KEY_W-1:0] top_key;
	logic [CNT_W-1:0]        entry_total;

	int             tx_idle_pct;
	int             rx_stall_pct;
	int             cycle_count;
	heap_scoreboard sb;

	max_heap_priority_queue_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.removed_key(removed_key),
		.top_valid  (top_valid),
		.top_key    (top_key),
		.entry_total(entry_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, removed_key, top_valid, top_key, entry_total);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// called and returning at a falling edge
	task automatic send_word(op_t op, logic signed [KEY_W-1:0] key);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		key_value = key;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_word(op, key);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
			3, 4, 5: return $signed($urandom_range(16)) - 32'sd8;
			default: return $signed($urandom);
		endcase
	endfunction

	// segments lean towards filling, emptying or holding the level
	task automatic run_random(int count);
		int  done;
		int  seg;
		int  ins_pct;
		op_t op;
		done = 0;
		while (done < count) begin
			case ($urandom_range(2))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			seg = $urandom_range(20, 120);
			for (int i = 0; i < seg && done < count; i++) begin
				op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE;
				send_word(op, (op == OP_INSERT) ? pick_key() : $signed($urandom));
				done++;
			end
			if ($urandom_range(7) == 0)
				drain();
		end
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		key_value = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// empty delete, extremes, equal keys, lone left child, tied children
		send_word(OP_DELETE, 32'sh7fffffff);
		send_word(OP_INSERT, 32'sh7fffffff);
		send_word(OP_INSERT, 32'sh80000000);
		send_word(OP_INSERT, 32'sd0);
		send_word(OP_INSERT, -32'sd1);
		send_word(OP_INSERT, 32'sd5);
		send_word(OP_INSERT, 32'sd5);
		repeat (7)
			send_word(OP_DELETE, 32'sh80000000);
		send_word(OP_INSERT, 32'sd9);
		send_word(OP_INSERT, 32'sd4);
		send_word(OP_INSERT, 32'sd4);
		send_word(OP_INSERT, 32'sd1);
		repeat (4)
			send_word(OP_DELETE, -32'sd1);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
				default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
			endcase
			run_random(PHASE_WORDS);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
